// ===== src/fpfa_pkg.sv =====
package fpfa_pkg;

   // Port field widths
   localparam int CMD_W      = 2;
   localparam int SLOT_W     = 4;
   localparam int AMT_W      = 16;
   localparam int POL_W      = 2;
   localparam int BIU_W      = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   // Fit policy codes; the unused code behaves as first fit
   localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
   localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
   localparam logic [POL_W-1:0] POL_WORST = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POLICY        = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCKS_IN_USE = 1'd1;

   // Register reset values
   localparam logic [POL_W-1:0] POLICY_RESET = POL_FIRST;
   localparam logic [BIU_W-1:0] BIU_RESET    = 5'd16;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } scan_state_type;

   // Busy mark update controls
   typedef struct packed {
      logic clear;
      logic set;
   } busy_ctl_type;

endpackage

// ===== src/fpfa_size_mem.sv =====
module fpfa_size_mem #(
   parameter int DEPTH  = 16,
   parameter int WIDTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/fpfa_busy_marks.sv =====
module fpfa_busy_marks #(
   parameter int NUM_BLOCKS = 16,
   parameter int IDX_W      = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  fpfa_pkg::busy_ctl_type ctl,
   input  logic [IDX_W-1:0]       set_idx,
   input  logic [IDX_W-1:0]       rd_idx,
   output logic                   rd_busy
);
   import fpfa_pkg::*;

   logic [NUM_BLOCKS-1:0] busy_ff;
   logic [NUM_BLOCKS-1:0] busy_in;

   // clear-all wins over a set; both never come in the same cycle
   always_comb begin
      busy_in = busy_ff;
      if (ctl.clear) begin
         busy_in = '0;
      end else if (ctl.set) begin
         busy_in[set_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign rd_busy = busy_ff[rd_idx];

endmodule

// ===== src/fpfa_scan.sv =====
module fpfa_scan #(
   parameter int NUM_BLOCKS = 16,
   parameter int SIZE_BITS  = 16,
   parameter int IDX_W      = 4,
   parameter int CNT_W      = 5
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [fpfa_pkg::CMD_W-1:0]   req_command,
   input  logic [fpfa_pkg::SLOT_W-1:0]  req_slot,
   input  logic [fpfa_pkg::AMT_W-1:0]   req_amount,
   input  logic [fpfa_pkg::POL_W-1:0]   policy,
   input  logic [CNT_W-1:0]             limit,
   output logic                         mem_we,
   output logic [IDX_W-1:0]             mem_waddr,
   output logic [SIZE_BITS-1:0]         mem_wdata,
   output logic                         mem_re,
   output logic [IDX_W-1:0]             mem_raddr,
   input  logic [SIZE_BITS-1:0]         mem_rdata,
   output fpfa_pkg::busy_ctl_type       busy_ctl,
   output logic [IDX_W-1:0]             busy_set_idx,
   output logic [IDX_W-1:0]             busy_rd_idx,
   input  logic                         busy_rd,
   output logic                         rsp_strobe,
   output logic                         rsp_granted,
   output logic [fpfa_pkg::SLOT_W-1:0]  rsp_chosen_block,
   output logic [fpfa_pkg::AMT_W-1:0]   rsp_chosen_size
);
   import fpfa_pkg::*;

   localparam int SLOT_CMP_W = (SLOT_W > CNT_W) ? SLOT_W + 1 : CNT_W + 1;

   scan_state_type state_ff, state_in;

   logic                 accept;
   logic                 slot_ok;
   logic                 alloc_go;
   logic                 alloc_none;
   logic                 last;
   logic                 fit;
   logic                 take;
   logic                 pick_vld_nx;
   logic [IDX_W-1:0]     pick_idx_nx;
   logic [SIZE_BITS-1:0] pick_size_nx;

   logic [SIZE_BITS-1:0] req_ff;
   logic [CNT_W-1:0]     lim_ff;
   logic [CNT_W-1:0]     iss_ff;
   logic                 eval_vld_ff;
   logic [IDX_W-1:0]     eval_idx_ff;
   logic                 pick_vld_ff;
   logic [IDX_W-1:0]     pick_idx_ff;
   logic [SIZE_BITS-1:0] pick_size_ff;
   logic                 rsp_strobe_ff;
   logic                 rsp_granted_ff;
   logic [SLOT_W-1:0]    rsp_block_ff;
   logic [AMT_W-1:0]     rsp_size_ff;

   // command decode
   assign accept     = start && (state_ff == ST_IDLE);
   assign slot_ok    = SLOT_CMP_W'(req_slot) < SLOT_CMP_W'(NUM_BLOCKS);
   assign alloc_go   = accept && (req_command == CMD_ALLOC) && (limit != '0);
   assign alloc_none = accept && (req_command == CMD_ALLOC) && (limit == '0);

   // evaluate the entry whose size just came out of the memory
   assign last = (state_ff == ST_SCAN) && eval_vld_ff &&
                 ((CNT_W'(eval_idx_ff) + CNT_W'(1)) == lim_ff);
   assign fit  = eval_vld_ff && !busy_rd && (mem_rdata >= req_ff);
   assign take = fit && (!pick_vld_ff ||
                         ((policy == POL_BEST)  && (mem_rdata < pick_size_ff)) ||
                         ((policy == POL_WORST) && (mem_rdata > pick_size_ff)));

   assign pick_vld_nx  = pick_vld_ff || take;
   assign pick_idx_nx  = take ? eval_idx_ff : pick_idx_ff;
   assign pick_size_nx = take ? mem_rdata : pick_size_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (alloc_go) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs toward memory and busy marks
   always_comb begin
      busy           = 1'b0;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      busy_ctl.clear = 1'b0;
      busy_ctl.set   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            mem_we         = accept && (req_command == CMD_LOAD) && slot_ok;
            busy_ctl.clear = accept && (req_command == CMD_CLEAR);
         end
         ST_SCAN: begin
            busy         = 1'b1;
            mem_re       = iss_ff < lim_ff;
            busy_ctl.set = last && pick_vld_nx;
         end
         default: ;
      endcase
   end

   assign mem_waddr    = IDX_W'(req_slot);
   assign mem_wdata    = SIZE_BITS'(req_amount);
   assign mem_raddr    = iss_ff[IDX_W-1:0];
   assign busy_rd_idx  = eval_idx_ff;
   assign busy_set_idx = pick_idx_nx;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         eval_vld_ff   <= 1'b0;
         pick_vld_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         eval_vld_ff   <= mem_re;
         pick_vld_ff   <= alloc_go ? 1'b0 : pick_vld_nx;
         rsp_strobe_ff <= last || alloc_none;
      end
   end

   // scan datapath
   always_ff @(posedge clock) begin
      if (alloc_go) begin
         req_ff <= SIZE_BITS'(req_amount);
         lim_ff <= limit;
         iss_ff <= '0;
      end else if (mem_re) begin
         iss_ff <= iss_ff + CNT_W'(1);
      end
      eval_idx_ff  <= iss_ff[IDX_W-1:0];
      pick_idx_ff  <= pick_idx_nx;
      pick_size_ff <= pick_size_nx;
   end

   // result beat
   always_ff @(posedge clock) begin
      if (last) begin
         rsp_granted_ff <= pick_vld_nx;
         rsp_block_ff   <= pick_vld_nx ? SLOT_W'(pick_idx_nx) : '0;
         rsp_size_ff    <= pick_vld_nx ? AMT_W'(pick_size_nx) : '0;
      end else if (alloc_none) begin
         rsp_granted_ff <= 1'b0;
         rsp_block_ff   <= '0;
         rsp_size_ff    <= '0;
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_granted      = rsp_granted_ff;
   assign rsp_chosen_block = rsp_block_ff;
   assign rsp_chosen_size  = rsp_size_ff;

`ifndef SYNTHESIS
   // a result beat only follows the end of a scan or an empty search
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> ($past(last) || $past(alloc_none)))
      else $error("result beat without a finished scan");

   // the read pointer never runs past the search limit
   a_iss_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (iss_ff <= lim_ff))
      else $error("scan read pointer beyond limit");

   // evaluated entries stay inside the search range
   a_eval_bound: assert property (@(posedge clock) disable iff (reset)
      eval_vld_ff |-> (CNT_W'(eval_idx_ff) < lim_ff))
      else $error("evaluated entry outside search range");

   // a refused request reports zero index and size
   a_refuse_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && !rsp_granted_ff) |-> ((rsp_block_ff == '0) && (rsp_size_ff == '0)))
      else $error("refused request with nonzero payload");

   // a scan ends with exactly one result beat next cycle
   a_scan_result: assert property (@(posedge clock) disable iff (reset)
      last |=> (rsp_strobe_ff && (state_ff == ST_IDLE)))
      else $error("scan end without result beat");
`endif

endmodule

// ===== src/fixed_partition_fit_allocator.sv =====
// Fixed partition fit allocator.
// Command channel: start with req_command, req_slot and req_amount; a beat is
// taken at a clock edge with start high and busy low. Load writes the size of
// partition req_slot, clear frees every partition, allocate searches the first
// blocks_in_use partitions for a free one of at least req_amount.
// Result channel: one beat per allocate, rsp_strobe high for one cycle with
// rsp_granted, rsp_chosen_block and rsp_chosen_size. The receiver has no
// backpressure; the beat must be taken in that cycle.
// Register port: csr_we, csr_index, csr_wdata; index 0 selects the policy
// (first, best, worst fit), index 1 the number of partitions searched.
// Timing: load and clear give no result. An allocate over N searched
// partitions reads the size memory once per partition, one read per cycle on
// its single read port, and its result is registered after the last entry is
// evaluated; busy drops in the cycle the result appears, so the next command
// can follow. An empty search answers in the cycle after the command.
// Reset: policy goes to first fit, the search count to 16 and every partition
// is free. Partition sizes are undefined until loaded.
module fixed_partition_fit_allocator #(
   parameter int NUM_BLOCKS = 16,
   parameter int SIZE_BITS  = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [fpfa_pkg::CMD_W-1:0]      req_command,
   input  logic [fpfa_pkg::SLOT_W-1:0]     req_slot,
   input  logic [fpfa_pkg::AMT_W-1:0]      req_amount,
   output logic                            rsp_strobe,
   output logic                            rsp_granted,
   output logic [fpfa_pkg::SLOT_W-1:0]     rsp_chosen_block,
   output logic [fpfa_pkg::AMT_W-1:0]      rsp_chosen_size,
   input  logic                            csr_we,
   input  logic [fpfa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fpfa_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import fpfa_pkg::*;

   localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
   localparam int CMP_W = (CNT_W > BIU_W) ? CNT_W : BIU_W;

   logic [POL_W-1:0]     policy_ff;
   logic [BIU_W-1:0]     biu_ff;
   logic [CNT_W-1:0]     limit;

   logic                 mem_we;
   logic [IDX_W-1:0]     mem_waddr;
   logic [SIZE_BITS-1:0] mem_wdata;
   logic                 mem_re;
   logic [IDX_W-1:0]     mem_raddr;
   logic [SIZE_BITS-1:0] mem_rdata;

   busy_ctl_type         busy_ctl;
   logic [IDX_W-1:0]     busy_set_idx;
   logic [IDX_W-1:0]     busy_rd_idx;
   logic                 busy_rd;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POLICY_RESET;
         biu_ff    <= BIU_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_POLICY:        policy_ff <= POL_W'(csr_wdata);
            CSR_BLOCKS_IN_USE: biu_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // search count saturates at the table depth
   assign limit = (CMP_W'(biu_ff) > CMP_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
                                                        : CNT_W'(biu_ff);

   fpfa_size_mem #(
      .DEPTH  (NUM_BLOCKS),
      .WIDTH  (SIZE_BITS),
      .ADDR_W (IDX_W)
   ) u_size_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   fpfa_busy_marks #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .IDX_W      (IDX_W)
   ) u_busy_marks (
      .clock   (clock),
      .reset   (reset),
      .ctl     (busy_ctl),
      .set_idx (busy_set_idx),
      .rd_idx  (busy_rd_idx),
      .rd_busy (busy_rd)
   );

   fpfa_scan #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .SIZE_BITS  (SIZE_BITS),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W)
   ) u_scan (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_slot         (req_slot),
      .req_amount       (req_amount),
      .policy           (policy_ff),
      .limit            (limit),
      .mem_we           (mem_we),
      .mem_waddr        (mem_waddr),
      .mem_wdata        (mem_wdata),
      .mem_re           (mem_re),
      .mem_raddr        (mem_raddr),
      .mem_rdata        (mem_rdata),
      .busy_ctl         (busy_ctl),
      .busy_set_idx     (busy_set_idx),
      .busy_rd_idx      (busy_rd_idx),
      .busy_rd          (busy_rd),
      .rsp_strobe       (rsp_strobe),
      .rsp_granted      (rsp_granted),
      .rsp_chosen_block (rsp_chosen_block),
      .rsp_chosen_size  (rsp_chosen_size)
   );

endmodule

// ===== tb/testbench.sv =====
module testbench;
   import fpfa_pkg::*;

   localparam int PARTITIONS = 16;
   localparam int NUM_PHASES = 8;

   // Codes the package leaves unnamed
   localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
   localparam logic [POL_W-1:0] POL_UNUSED  = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [SLOT_W-1:0] slot;
      logic [AMT_W-1:0]  amount;
   } cmd_beat_type;

   typedef struct packed {
      logic              granted;
      logic [SLOT_W-1:0] block;
      logic [AMT_W-1:0]  size;
   } grant_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [CMD_W-1:0]      req_command = CMD_LOAD;
   logic [SLOT_W-1:0]     req_slot = '0;
   logic [AMT_W-1:0]      req_amount = '0;
   logic                  rsp_strobe;
   logic                  rsp_granted;
   logic [SLOT_W-1:0]     rsp_chosen_block;
   logic [AMT_W-1:0]      rsp_chosen_size;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_POLICY;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Allocator mirror: partition table, busy marks and register copies
   logic [AMT_W-1:0]      part_size [PARTITIONS];
   logic [PARTITIONS-1:0] part_busy = '0;
   logic [POL_W-1:0]      fit_policy = POLICY_RESET;
   logic [BIU_W-1:0]      fit_count = BIU_RESET;

   cmd_beat_type cmd_queue [$];
   grant_type    grant_queue [$];
   cmd_beat_type drive_beat;
   grant_type    seen_grant;
   grant_type    want_grant;

   int idle_pct = 26;
   int errors = 0;
   int n_beats = 0;
   int n_grants = 0;
   int n_refusals = 0;

   // Search settings per random phase: policy, partitions searched, idling, beats
   logic [POL_W-1:0] plan_policy [NUM_PHASES] =
      '{POL_BEST, POL_WORST, POL_UNUSED, POL_FIRST, POL_BEST, POL_WORST, POL_BEST, POL_FIRST};
   logic [BIU_W-1:0] plan_count [NUM_PHASES] =
      '{5'd16, 5'd16, 5'd16, 5'd31, 5'd1, 5'd0, 5'd7, 5'd16};
   int plan_idle [NUM_PHASES] = '{26, 0, 26, 26, 26, 26, 26, 26};
   int plan_beats [NUM_PHASES] = '{60, 60, 40, 50, 40, 30, 60, 60};

   fixed_partition_fit_allocator u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_slot         (req_slot),
      .req_amount       (req_amount),
      .rsp_strobe       (rsp_strobe),
      .rsp_granted      (rsp_granted),
      .rsp_chosen_block (rsp_chosen_block),
      .rsp_chosen_size  (rsp_chosen_size),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #2 clock = ~clock;

   // Apply one accepted command to the mirror; an allocate queues its grant
   function automatic void predict_command(input logic [CMD_W-1:0] cmd,
                                           input logic [SLOT_W-1:0] slot,
                                           input logic [AMT_W-1:0] amt);
      int        limit;
      int        pick;
      int        i;
      grant_type g;
      case (cmd)
         CMD_LOAD: begin
            part_size[slot] = amt;
         end
         CMD_CLEAR: begin
            part_busy = '0;
         end
         CMD_ALLOC: begin
            limit = (fit_count > PARTITIONS) ? PARTITIONS : int'(fit_count);
            pick = -1;
            for (i = 0; i < limit; i++) begin
               if (!part_busy[i] && part_size[i] >= amt) begin
                  if (pick < 0)
                     pick = i;
                  else if (fit_policy == POL_BEST && part_size[i] < part_size[pick])
                     pick = i;
                  else if (fit_policy == POL_WORST && part_size[i] > part_size[pick])
                     pick = i;
               end
            end
            g = '0;
            if (pick >= 0) begin
               part_busy[pick] = 1'b1;
               g.granted = 1'b1;
               g.block = SLOT_W'(pick);
               g.size = part_size[pick];
            end
            grant_queue.push_back(g);
         end
         default: ;
      endcase
   endfunction

   // Sizes cluster on multiples of 16 so best and worst fit see plenty of ties
   function automatic logic [AMT_W-1:0] pick_amount();
      case ($urandom_range(5))
         0, 1: return AMT_W'($urandom_range(8) * 16);
         2: return AMT_W'($urandom_range(200));
         3: return AMT_W'($urandom);
         4: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
         default: return AMT_W'($urandom_range(160));
      endcase
   endfunction

   function automatic cmd_beat_type random_beat();
      cmd_beat_type b;
      int           r;
      r = $urandom_range(99);
      b.slot = SLOT_W'($urandom);
      b.amount = pick_amount();
      if (r < 55)
         b.command = CMD_ALLOC;
      else if (r < 82)
         b.command = CMD_LOAD;
      else if (r < 92)
         b.command = CMD_CLEAR;
      else
         b.command = CMD_UNKNOWN;
      return b;
   endfunction

   task automatic add_beat(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                           input logic [AMT_W-1:0] amt);
      cmd_queue.push_back('{command: cmd, slot: slot, amount: amt});
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_POLICY)
         fit_policy = data[POL_W-1:0];
      else
         fit_count = data[BIU_W-1:0];
   endtask

   // Hold the sender until every beat is taken and every grant has come back
   task automatic drain();
      while (cmd_queue.size() != 0 || start || busy || grant_queue.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Command driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predict_command(req_command, req_slot, req_amount);
            n_beats++;
         end
         if (!start || !busy) begin
            if (cmd_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
               drive_beat = cmd_queue.pop_front();
               start <= 1'b1;
               req_command <= drive_beat.command;
               req_slot <= drive_beat.slot;
               req_amount <= drive_beat.amount;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Grant monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         seen_grant = '{granted: rsp_granted, block: rsp_chosen_block, size: rsp_chosen_size};
         if (grant_queue.size() == 0) begin
            $error("unexpected result beat: granted %0d block %0d size %0d",
                   rsp_granted, rsp_chosen_block, rsp_chosen_size);
            errors++;
         end else begin
            want_grant = grant_queue.pop_front();
            if (seen_grant.granted !== want_grant.granted) begin
               $error("rsp_granted: expected %0d, got %0d", want_grant.granted, rsp_granted);
               errors++;
            end
            if (seen_grant.block !== want_grant.block) begin
               $error("rsp_chosen_block: expected %0d, got %0d",
                      want_grant.block, rsp_chosen_block);
               errors++;
            end
            if (seen_grant.size !== want_grant.size) begin
               $error("rsp_chosen_size: expected %0d, got %0d",
                      want_grant.size, rsp_chosen_size);
               errors++;
            end
            if (want_grant.granted)
               n_grants++;
            else
               n_refusals++;
         end
      end
   end

   // Stimulus
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: first fit over four partitions
      write_csr(CSR_POLICY, CSR_DATA_W'(POL_FIRST));
      write_csr(CSR_BLOCKS_IN_USE, 5'd4);
      add_beat(CMD_LOAD, 4'd0, 16'hFFFF);
      add_beat(CMD_LOAD, 4'd1, 16'd0);
      add_beat(CMD_LOAD, 4'd2, 16'd100);
      add_beat(CMD_LOAD, 4'd3, 16'd100);
      add_beat(CMD_LOAD, 4'd15, 16'h1234);
      add_beat(CMD_UNKNOWN, 4'd5, 16'hFFFF);   // ignored, no result
      add_beat(CMD_ALLOC, 4'd0, 16'd0);        // zero request takes the first free
      add_beat(CMD_ALLOC, 4'd0, 16'hFFFF);     // largest is busy: refused
      add_beat(CMD_ALLOC, 4'd0, 16'd100);
      add_beat(CMD_ALLOC, 4'd0, 16'd100);
      add_beat(CMD_ALLOC, 4'd0, 16'd1);
      add_beat(CMD_LOAD, 4'd2, 16'd7);         // resize a busy partition, stays busy
      add_beat(CMD_ALLOC, 4'd0, 16'd0);
      add_beat(CMD_ALLOC, 4'd0, 16'd0);        // everything busy
      add_beat(CMD_CLEAR, 4'd0, 16'd0);
      add_beat(CMD_ALLOC, 4'd0, 16'd7);
      add_beat(CMD_ALLOC, 4'd0, 16'd5);
      add_beat(CMD_ALLOC, 4'd0, 16'hFFFF);
      drain();

      // Random phases, one register setting each
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_csr(CSR_POLICY, {3'($urandom_range(7)), plan_policy[p]});
         write_csr(CSR_BLOCKS_IN_USE, plan_count[p]);
         idle_pct = plan_idle[p];
         // every partition gets a size before any wide search
         if (p == 0) begin
            for (int s = 0; s < PARTITIONS; s++)
               add_beat(CMD_LOAD, SLOT_W'(s), pick_amount());
         end
         for (int n = 0; n < plan_beats[p]; n++)
            cmd_queue.push_back(random_beat());
         drain();
      end

      repeat (24) @(posedge clock);
      $display("covered %0d command beats over %0d register settings", n_beats,
               NUM_PHASES + 1);
      $display("allocations: %0d granted, %0d refused", n_grants, n_refusals);
      if (errors == 0 && grant_queue.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #800000;
      $display("tb: failure");
      $finish;
   end

endmodule
